// ===== sv/dpb_pkg.sv =====
// Types, register map and rounding helper for the depth pixel back-projection block.
`timescale 1ns / 1ps

package dpb_pkg;

    typedef logic        [15:0] t_depth;
    typedef logic        [11:0] t_pix;
    typedef logic        [15:0] t_center;
    typedef logic        [23:0] t_inv;
    typedef logic signed [23:0] t_coord;

    // Product widths along the pipeline.
    typedef logic [31:0] t_prod1;
    typedef logic [55:0] t_prod2;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Fraction bits of the final product: four from Q12.4 and twenty-four from Q0.24.
    localparam int FRAC_BITS = 28;

    localparam t_center RST_CENTER_X    = 16'd5120;
    localparam t_center RST_CENTER_Y    = 16'd3840;
    localparam t_inv    RST_INV_FOCAL_X = 24'd33554;
    localparam t_inv    RST_INV_FOCAL_Y = 24'd33554;
    localparam t_depth  RST_DEPTH_LIMIT = 16'd65535;

    typedef enum logic [ADDR_W-1:0] {
        REG_CENTER_X    = 5'd0,
        REG_CENTER_Y    = 5'd4,
        REG_INV_FOCAL_X = 5'd8,
        REG_INV_FOCAL_Y = 5'd12,
        REG_DEPTH_LIMIT = 5'd16
    } t_reg_addr;

    // Rounds the magnitude to nearest (ties away from zero), restores the sign
    // and saturates to the signed 24-bit coordinate range.
    function automatic t_coord round_sat(input t_prod2 prod, input logic neg);
        logic [56:0] sum;
        logic [28:0] q;
        t_coord      res;
        sum = {1'b0, prod} + (57'd1 << (FRAC_BITS - 1));
        q   = sum[56:FRAC_BITS];
        if (neg) begin
            if (q > 29'd8388608) begin
                res = 24'sh800000;
            end else begin
                res = t_coord'(~q[23:0] + 24'd1);
            end
        end else begin
            if (q > 29'd8388607) begin
                res = 24'sh7FFFFF;
            end else begin
                res = t_coord'(q[23:0]);
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/depth_pixel_backprojection.sv =====
// Pinhole back-projection of depth pixels to camera-frame points, with its register port.
`timescale 1ns / 1ps

// Each request carries one depth pixel with its column and row. A pixel deeper
// than the depth limit is dropped and yields no point; a depth equal to the limit
// is kept. A kept pixel yields x = (col - cx) * depth / fx, y = (row - cy) *
// depth / fy and z = depth, where cx and cy are Q12.4 pixel positions and the
// divisions are multiplications by the Q0.24 reciprocal focal lengths. The
// result is rounded to nearest, ties away from zero, and x and y saturate to
// signed 24 bits. The block takes one request per clock while its input is
// not stalled. Each point passes through a four-stage pipeline: centre offset,
// offset times depth (16 by 16 bits), that product times the reciprocal focal
// length (32 by 24 bits), and rounding with saturation into the output
// register. Each stage holds its contents while the stage after it is full and
// stalled, so bubbles are squeezed out and the input only stalls when all four
// stages are full and the output is stalled. Configuration is written through
// the APB-style port; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module depth_pixel_backprojection (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpb_pkg::ADDR_W-1:0]  paddr,
    input  logic [dpb_pkg::DATA_W-1:0]  pwdata,
    output logic [dpb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  dpb_pkg::t_depth             i_depth,
    input  dpb_pkg::t_pix               i_col,
    input  dpb_pkg::t_pix               i_row,

    output logic                        o_valid,
    input  logic                        i_stall,
    output dpb_pkg::t_coord             o_point_x,
    output dpb_pkg::t_coord             o_point_y,
    output dpb_pkg::t_depth             o_point_z
);

    import dpb_pkg::*;

    // Configuration registers.
    t_center r_center_x;
    t_center r_center_y;
    t_inv    r_inv_focal_x;
    t_inv    r_inv_focal_y;
    t_depth  r_depth_limit;

    logic    w_cfg_wr;

    // Pipeline registers.
    logic    r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic    w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic    r_s1_neg_x, r_s1_neg_y;
    t_depth  r_s1_mag_x, r_s1_mag_y, r_s1_depth;

    logic    r_s2_neg_x, r_s2_neg_y;
    t_prod1  r_s2_prod_x, r_s2_prod_y;
    t_depth  r_s2_depth;

    logic    r_s3_neg_x, r_s3_neg_y;
    t_prod2  r_s3_prod_x, r_s3_prod_y;
    t_depth  r_s3_depth;

    t_coord  r_s4_point_x, r_s4_point_y;
    t_depth  r_s4_point_z;

    // First-stage combinational signals.
    logic        w_keep;
    logic [16:0] w_diff_x, w_diff_y;
    logic [16:0] w_abs_x, w_abs_y;

    // ------------------------------------------------------------------
    // Register port. Writes complete in the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= RST_CENTER_X;
            r_center_y    <= RST_CENTER_Y;
            r_inv_focal_x <= RST_INV_FOCAL_X;
            r_inv_focal_y <= RST_INV_FOCAL_Y;
            r_depth_limit <= RST_DEPTH_LIMIT;
        end else if (w_cfg_wr) begin
            unique case (paddr)
                REG_CENTER_X:    r_center_x    <= pwdata[15:0];
                REG_CENTER_Y:    r_center_y    <= pwdata[15:0];
                REG_INV_FOCAL_X: r_inv_focal_x <= pwdata[23:0];
                REG_INV_FOCAL_Y: r_inv_focal_y <= pwdata[23:0];
                REG_DEPTH_LIMIT: r_depth_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            REG_CENTER_X:    prdata = {16'd0, r_center_x};
            REG_CENTER_Y:    prdata = {16'd0, r_center_y};
            REG_INV_FOCAL_X: prdata = {8'd0, r_inv_focal_x};
            REG_INV_FOCAL_Y: prdata = {8'd0, r_inv_focal_y};
            REG_DEPTH_LIMIT: prdata = {16'd0, r_depth_limit};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. A stage may load when it is empty or when the stage
    // after it is loading, so a gap anywhere in the pipeline is filled.
    // ------------------------------------------------------------------
    assign w_rdy4  = !r_s4_valid || !i_stall;
    assign w_rdy3  = !r_s3_valid || w_rdy4;
    assign w_rdy2  = !r_s2_valid || w_rdy3;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_stall = !w_rdy1;

    // ------------------------------------------------------------------
    // Stage 1: depth test and signed centre offsets in Q12.4, kept as sign
    // and magnitude. A dropped pixel simply enters as a bubble.
    // ------------------------------------------------------------------
    assign w_keep   = (i_depth <= r_depth_limit);
    assign w_diff_x = {1'b0, i_col, 4'd0} - {1'b0, r_center_x};
    assign w_diff_y = {1'b0, i_row, 4'd0} - {1'b0, r_center_y};
    assign w_abs_x  = w_diff_x[16] ? (~w_diff_x + 17'd1) : w_diff_x;
    assign w_abs_y  = w_diff_y[16] ? (~w_diff_y + 17'd1) : w_diff_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_valid <= i_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_neg_x <= w_diff_x[16];
            r_s1_neg_y <= w_diff_y[16];
            r_s1_mag_x <= w_abs_x[15:0];
            r_s1_mag_y <= w_abs_y[15:0];
            r_s1_depth <= i_depth;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: offset magnitude times depth.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_neg_x  <= r_s1_neg_x;
            r_s2_neg_y  <= r_s1_neg_y;
            r_s2_prod_x <= t_prod1'(r_s1_mag_x) * t_prod1'(r_s1_depth);
            r_s2_prod_y <= t_prod1'(r_s1_mag_y) * t_prod1'(r_s1_depth);
            r_s2_depth  <= r_s1_depth;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: times the reciprocal focal length, 28 fraction bits result.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_rdy3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_neg_x  <= r_s2_neg_x;
            r_s3_neg_y  <= r_s2_neg_y;
            r_s3_prod_x <= t_prod2'(r_s2_prod_x) * t_prod2'(r_inv_focal_x);
            r_s3_prod_y <= t_prod2'(r_s2_prod_y) * t_prod2'(r_inv_focal_y);
            r_s3_depth  <= r_s2_depth;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rounding and saturation into the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_rdy4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_point_x <= round_sat(r_s3_prod_x, r_s3_neg_x);
            r_s4_point_y <= round_sat(r_s3_prod_y, r_s3_neg_y);
            r_s4_point_z <= r_s3_depth;
        end
    end

    assign o_valid   = r_s4_valid;
    assign o_point_x = r_s4_point_x;
    assign o_point_y = r_s4_point_y;
    assign o_point_z = r_s4_point_z;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input is only held off when every stage is occupied and the output waits.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_s4_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    // A pixel beyond the depth limit never enters the pipeline.
    a_drop_deep_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_depth > r_depth_limit)) |=> !r_s1_valid)
        else $error("pixel beyond the depth limit was kept");

    // A point leaving the last working stage reaches the output register.
    a_stage3_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && w_rdy4) |=> o_valid)
        else $error("point lost between the multiplier and the output register");

    // A zero depth projects to the origin.
    a_zero_depth_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_point_z == 16'd0)) |-> ((o_point_x == 24'sd0) && (o_point_y == 24'sd0)))
        else $error("zero depth gave a point away from the origin");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the depth pixel back-projection block.
`timescale 1ns / 1ps

// The testbench streams depth pixel requests into the block and checks every
// camera-frame point that comes out against its own integer model of the
// pinhole back-projection. The run is split into phases. Each phase starts
// with the block idle. All but the first programme all five registers through
// the APB-style port (plus a write to an unmapped address, which must change
// nothing); each phase then queues a batch of requests. A phase ends once
// every queued request has been taken, every predicted point has been seen
// and the pipeline has had time to drain any dropped pixels.
//
// The first phases are directed: reset values, depth exactly at and just
// above the limit, zero depth, saturation in both directions, zero reciprocal
// focal lengths and rounding ties. The rest are random phases with random
// register settings, one of which runs with no idling at all and has the
// receiver hold off for a long stretch so that the pipeline fills and the
// block stalls its input.
module tb_top;

    import dpb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PCT       = 19;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 52;
    localparam int PRESSURE_ITEMS = 100;
    localparam int PRESSURE_PHASE = 3;

    localparam longint unsigned COORD_MAX_MAG = 64'd8388607;
    localparam longint unsigned COORD_MIN_MAG = 64'd8388608;

    // Addresses 20, 24 and 28 decode to no register.
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED_BASE = 5'd20;

    localparam t_center CENTER_MAX = 16'hFFFF;
    localparam t_inv    INV_MAX    = 24'hFFFFFF;
    localparam t_depth  DEPTH_MAX  = 16'hFFFF;
    localparam t_pix    PIX_MAX    = 12'hFFF;

    typedef struct {
        t_depth depth;
        t_pix   col;
        t_pix   row;
    } t_pixel_req;

    typedef struct {
        t_coord x;
        t_coord y;
        t_depth z;
    } t_point;

    // Clock, reset and every block input start from a known value.
    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              i_valid = 1'b0;
    logic              o_stall;
    t_depth            i_depth = '0;
    t_pix              i_col   = '0;
    t_pix              i_row   = '0;

    logic              o_valid;
    logic              i_stall = 1'b0;
    t_coord            o_point_x;
    t_coord            o_point_y;
    t_depth            o_point_z;

    // The testbench's own copy of the register file. It only changes while
    // the block is idle, so the driver may read it at any acceptance.
    t_center cfg_center_x    = RST_CENTER_X;
    t_center cfg_center_y    = RST_CENTER_Y;
    t_inv    cfg_inv_focal_x = RST_INV_FOCAL_X;
    t_inv    cfg_inv_focal_y = RST_INV_FOCAL_Y;
    t_depth  cfg_depth_limit = RST_DEPTH_LIMIT;

    t_pixel_req pixel_queue[$];
    t_point     point_queue[$];

    int error_count  = 0;
    int quiet_cycles = 0;

    // calm_mode switches idling off on both sides; hold_req asks the
    // receiver, once, for its long hold-off.
    logic calm_mode = 1'b0;
    logic hold_req  = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left  = 0;

    depth_pixel_backprojection DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_depth   (i_depth),
        .i_col     (i_col),
        .i_row     (i_row),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // One back-projected coordinate. The offset from the principal point is
    // taken as a magnitude and a sign, the magnitude product is rounded half
    // away from zero at bit 28, and the signed result is clamped to 24 bits.
    function automatic t_coord backproject(t_pix pix, t_center center, t_depth depth, t_inv inv);
        logic [15:0]     pix_q4;
        logic            below;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned q;
        longint unsigned neg_q;
        t_coord          coord;
        pix_q4 = {pix, 4'b0000};
        below  = pix_q4 < center;
        mag    = below ? longint'(center) - longint'(pix_q4)
                       : longint'(pix_q4) - longint'(center);
        prod   = mag * longint'(depth) * longint'(inv);
        q      = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (below) begin
            neg_q = 64'd0 - ((q > COORD_MIN_MAG) ? COORD_MIN_MAG : q);
            coord = neg_q[23:0];
        end else begin
            coord = (q > COORD_MAX_MAG) ? COORD_MAX_MAG[23:0] : q[23:0];
        end
        return coord;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    // Driver: takes requests from the pending queue, holds a stalled request
    // steady, and predicts the point for each accepted request within the limit.
    always @(posedge i_clk) begin
        t_pixel_req req;
        t_point     pt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall && i_depth <= cfg_depth_limit) begin
                pt.x = backproject(i_col, cfg_center_x, i_depth, cfg_inv_focal_x);
                pt.y = backproject(i_row, cfg_center_y, i_depth, cfg_inv_focal_y);
                pt.z = i_depth;
                point_queue = {point_queue, pt};
            end
            if (!i_valid || !o_stall) begin
                if (pixel_queue.size() > 0 &&
                    (calm_mode || $urandom_range(99) >= IDLE_PCT)) begin
                    req = pixel_queue.pop_front();
                    i_valid <= 1'b1;
                    i_depth <= req.depth;
                    i_col   <= req.col;
                    i_row   <= req.row;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted point against the oldest prediction and
    // drives the output stall, including the one long hold-off.
    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (point_queue.size() == 0) begin
                    report_mismatch($sformatf("point (%0d, %0d, %0d) with nothing predicted",
                                              o_point_x, o_point_y, o_point_z));
                end else begin
                    want = point_queue.pop_front();
                    if (o_point_x !== want.x) begin
                        report_mismatch($sformatf("point_x is %0d, predicted %0d",
                                                  o_point_x, want.x));
                    end
                    if (o_point_y !== want.y) begin
                        report_mismatch($sformatf("point_y is %0d, predicted %0d",
                                                  o_point_y, want.y));
                    end
                    if (o_point_z !== want.z) begin
                        report_mismatch($sformatf("point_z is %0d, predicted %0d",
                                                  o_point_z, want.z));
                    end
                end
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm_mode && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // A register write: setup cycle, access cycle, done once pready is seen.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Programmes every register. Bits above each register's width carry
    // random noise, which the block must ignore. A final write to an
    // unmapped address must leave the register file as it is.
    task automatic set_config(input t_center cx, input t_center cy, input t_inv ifx,
                              input t_inv ify, input t_depth lim);
        logic [DATA_W-1:0] data;
        data = $urandom(); data[15:0] = cx;
        write_reg(REG_CENTER_X, data);
        data = $urandom(); data[15:0] = cy;
        write_reg(REG_CENTER_Y, data);
        data = $urandom(); data[23:0] = ifx;
        write_reg(REG_INV_FOCAL_X, data);
        data = $urandom(); data[23:0] = ify;
        write_reg(REG_INV_FOCAL_Y, data);
        data = $urandom(); data[15:0] = lim;
        write_reg(REG_DEPTH_LIMIT, data);
        write_reg(ADDR_UNMAPPED_BASE + 5'(4 * $urandom_range(2)), $urandom());
        cfg_center_x    = cx;
        cfg_center_y    = cy;
        cfg_inv_focal_x = ifx;
        cfg_inv_focal_y = ify;
        cfg_depth_limit = lim;
        // Requests are queued away from the clock edge.
        @(negedge i_clk);
    endtask

    task automatic queue_pixel(input t_depth depth, input t_pix col, input t_pix row);
        t_pixel_req req;
        req.depth = depth;
        req.col   = col;
        req.row   = row;
        pixel_queue = {pixel_queue, req};
    endtask

    // Waits until the block has taken and answered everything, then lets the
    // pipeline run empty of any dropped pixels still in flight.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_queue.size() != 0 || i_valid || point_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_center pick_center();
        case ($urandom_range(3))
            0:       return '0;
            1:       return CENTER_MAX;
            default: return t_center'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_inv pick_inv();
        case ($urandom_range(3))
            0:       return t_inv'(1);
            1:       return INV_MAX;
            2:       return t_inv'($urandom_range(60000, 16000));
            default: return t_inv'($urandom());
        endcase
    endfunction

    function automatic t_depth pick_limit();
        case ($urandom_range(3))
            0:       return DEPTH_MAX;
            1:       return t_depth'($urandom_range(4000, 100));
            default: return t_depth'($urandom_range(65535));
        endcase
    endfunction

    // Depths cluster around the limit and the ends of the range so that both
    // the drop test and the saturation logic see their boundaries often.
    function automatic t_depth pick_depth();
        case ($urandom_range(7))
            0:       return cfg_depth_limit;
            1:       return cfg_depth_limit + 16'd1;
            2:       return cfg_depth_limit - 16'd1;
            3:       return '0;
            4:       return DEPTH_MAX;
            default: return t_depth'($urandom_range(65535));
        endcase
    endfunction

    // Pixel positions near the principal point exercise small offsets and
    // rounding; the ends of the range exercise saturation.
    function automatic t_pix pick_pix(input t_center center);
        case ($urandom_range(5))
            0:       return '0;
            1:       return PIX_MAX;
            2:       return t_pix'(center[15:4] + 12'($urandom_range(4)) - 12'd2);
            default: return t_pix'($urandom_range(4095));
        endcase
    endfunction

    initial begin : main
        int n_items;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values, before any register write: origin, far corners and
        // the exact principal point.
        queue_pixel(16'd0, 12'd0, 12'd0);
        queue_pixel(DEPTH_MAX, 12'd0, 12'd0);
        queue_pixel(DEPTH_MAX, PIX_MAX, PIX_MAX);
        queue_pixel(DEPTH_MAX, 12'd320, 12'd240);
        queue_pixel(16'd1, 12'd321, 12'd241);
        queue_pixel(16'd12345, 12'd100, 12'd400);
        wait_idle();

        // Depth at the limit is kept, one above is dropped; large offsets with
        // the largest reciprocal saturate negative in x and positive in y.
        set_config(CENTER_MAX, 16'd0, INV_MAX, INV_MAX, 16'd40000);
        queue_pixel(16'd40000, 12'd0, PIX_MAX);
        queue_pixel(16'd40001, 12'd0, PIX_MAX);
        queue_pixel(16'd39999, PIX_MAX, 12'd0);
        queue_pixel(16'd0, PIX_MAX, 12'd0);
        queue_pixel(DEPTH_MAX, 12'd2048, 12'd2048);
        queue_pixel(16'd3000, 12'd2048, 12'd2048);
        wait_idle();

        // Zero reciprocal focal lengths and a zero limit: only zero depth
        // survives, and every coordinate is zero.
        set_config(16'd0, CENTER_MAX, '0, '0, 16'd0);
        queue_pixel(16'd0, PIX_MAX, PIX_MAX);
        queue_pixel(16'd1, 12'd0, 12'd0);
        queue_pixel(DEPTH_MAX, PIX_MAX, PIX_MAX);
        queue_pixel(16'd0, 12'd0, 12'd0);
        wait_idle();

        // Rounding ties: 16 * 8192 * 1024 is exactly one half, which must
        // round away from zero on either side of the principal point.
        set_config(16'd32, 16'd0, 24'd1024, 24'd1024, DEPTH_MAX);
        queue_pixel(16'd8192, 12'd1, 12'd1);
        queue_pixel(16'd8191, 12'd1, 12'd1);
        queue_pixel(16'd8192, 12'd3, 12'd3);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_config(pick_center(), pick_center(), pick_inv(), pick_inv(), pick_limit());
            n_items = PHASE_ITEMS;
            if (phase == PRESSURE_PHASE) begin
                // No idling on either side, and the receiver holds off long
                // enough for the pipeline to fill and stall the input.
                calm_mode <= 1'b1;
                hold_req  <= 1'b1;
                n_items = PRESSURE_ITEMS;
            end
            for (int k = 0; k < n_items; k++) begin
                queue_pixel(pick_depth(), pick_pix(cfg_center_x), pick_pix(cfg_center_y));
            end
            wait_idle();
            calm_mode <= 1'b0;
        end

        while (point_queue.size() > 0) begin
            void'(point_queue.pop_front());
            report_mismatch("predicted point never arrived");
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
